@@ src/m3i_pkg.sv @@
// Package: payload types and fixed widths for the 3x3 adjugate inverse.
package m3i_pkg;
    localparam int ElemW = 24;
    localparam int OutW  = 32;
    localparam int CofW  = 2 * ElemW + 1;
    localparam int DetW  = CofW + ElemW + 2;

    typedef struct packed {
        logic signed [ElemW-1:0] m_r0c0;
        logic signed [ElemW-1:0] m_r0c1;
        logic signed [ElemW-1:0] m_r0c2;
        logic signed [ElemW-1:0] m_r1c0;
        logic signed [ElemW-1:0] m_r1c1;
        logic signed [ElemW-1:0] m_r1c2;
        logic signed [ElemW-1:0] m_r2c0;
        logic signed [ElemW-1:0] m_r2c1;
        logic signed [ElemW-1:0] m_r2c2;
    } t_mat_in;

    typedef struct packed {
        logic signed [OutW-1:0] inv_r0c0;
        logic signed [OutW-1:0] inv_r0c1;
        logic signed [OutW-1:0] inv_r0c2;
        logic signed [OutW-1:0] inv_r1c0;
        logic signed [OutW-1:0] inv_r1c1;
        logic signed [OutW-1:0] inv_r1c2;
        logic signed [OutW-1:0] inv_r2c0;
        logic signed [OutW-1:0] inv_r2c1;
        logic signed [OutW-1:0] inv_r2c2;
        logic                   singular;
    } t_mat_out;
endpackage

@@ src/matrix3_inverse_adjugate.sv @@
// Top level: 3x3 matrix inverse by the adjugate, Q12.12 in, Q16.16 out.
// Takes one matrix per cycle when the output side keeps up; the whole pipeline advances
// together through five cofactor and determinant stages, then an operand stage, 34
// quotient-bit stages and a rounding stage in each of the nine parallel dividers. A
// stalled output freezes every stage. A zero determinant gives singular = 1 and all
// entries zero; entries round to nearest and saturate to 32 bits.
module matrix3_inverse_adjugate import m3i_pkg::*; #(
    parameter int IN_FRAC_BITS  = 12,
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_mat_in  i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_mat_out o_data
);
    localparam int Depth = OutW + 4;
    logic en, fv;
    logic signed [CofW-1:0] cof [9];
    logic signed [DetW-1:0] det;
    logic signed [OutW-1:0] q [9];
    logic [Depth-1:0] r_v;
    logic [Depth-1:0] r_z;

    assign en = !o_valid || i_ready;
    assign o_ready = en;

    m3i_front u_front (
        .i_clk, .i_rst_n, .i_en(en), .i_valid, .i_mat(i_data),
        .o_valid(fv), .o_cof(cof), .o_det(det)
    );

    for (genvar k = 0; k < 9; k++) begin : g_div
        m3i_div #(.ShiftW(IN_FRAC_BITS + OUT_FRAC_BITS)) u_div (
            .i_clk, .i_en(en), .i_cof(cof[3*(k%3)+k/3]), .i_det(det), .o_q(q[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[Depth-2:0], fv};
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) r_z <= {r_z[Depth-2:0], det == '0};
    end

    assign o_valid = r_v[Depth-1];
    always_comb begin
        o_data = {q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7], q[8], 1'b0};
        if (r_z[Depth-1]) begin
            o_data = '0;
            o_data.singular = 1'b1;
        end
    end
endmodule

@@ src/m3i_front.sv @@
// Cofactor and determinant stages: products, cofactors, split partial products, terms, det.
module m3i_front import m3i_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  t_mat_in               i_mat,
    output logic                  o_valid,
    output logic signed [CofW-1:0] o_cof [9],
    output logic signed [DetW-1:0] o_det
);
    localparam int LoW = CofW - ElemW;

    logic signed [ElemW-1:0] a [9];
    logic signed [2*ElemW-1:0] r_p [18];
    logic signed [ElemW-1:0] r_a0 [3];
    logic signed [ElemW-1:0] r_a1 [3];
    logic signed [CofW-1:0] r_cof [9];
    logic signed [CofW-1:0] r_cof2 [9];
    logic signed [CofW-1:0] r_cof3 [9];
    logic signed [ElemW+LoW:0] r_tl [3];
    logic signed [2*ElemW-1:0] r_th [3];
    logic signed [DetW-1:0] r_t [3];
    logic signed [DetW-1:0] r_det;
    logic [4:0] r_v;
    logic signed [CofW-1:0] n_cof [9];

    assign a = '{i_mat.m_r0c0, i_mat.m_r0c1, i_mat.m_r0c2, i_mat.m_r1c0, i_mat.m_r1c1,
                 i_mat.m_r1c2, i_mat.m_r2c0, i_mat.m_r2c1, i_mat.m_r2c2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_cof[k] = (CofW'(r_p[2*k]) - CofW'(r_p[2*k+1]));
            if (k % 2 == 1) n_cof[k] = -n_cof[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_p[2*(3*r+c)]   <= a[3*(r==0?1:0)+(c==0?1:0)] * a[3*(r==2?1:2)+(c==2?1:2)];
                    r_p[2*(3*r+c)+1] <= a[3*(r==0?1:0)+(c==2?1:2)] * a[3*(r==2?1:2)+(c==0?1:0)];
                end
            end
            for (int c = 0; c < 3; c++) r_a0[c] <= a[c];
            r_a1 <= r_a0;
            r_cof <= n_cof;
            for (int c = 0; c < 3; c++) begin
                r_tl[c] <= r_a1[c] * $signed({1'b0, r_cof[c][LoW-1:0]});
                r_th[c] <= r_a1[c] * $signed(r_cof[c][CofW-1:LoW]);
            end
            r_cof2 <= r_cof;
            for (int c = 0; c < 3; c++) r_t[c] <= (DetW'(r_th[c]) <<< LoW) + DetW'(r_tl[c]);
            r_cof3 <= r_cof2;
            r_det <= r_t[0] + r_t[1] + r_t[2];
            o_cof <= r_cof3;
        end
    end
    assign o_det = r_det;
    assign o_valid = r_v[4];
endmodule

@@ src/m3i_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, with rounding and saturation.
module m3i_div import m3i_pkg::*; #(
    parameter int ShiftW = 28
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [CofW-1:0] i_cof,
    input  logic signed [DetW-1:0] i_det,
    output logic signed [OutW-1:0] o_q
);
    localparam int MagW = CofW;
    localparam int QW   = OutW + 2;
    localparam int NumW = MagW + ShiftW;
    localparam int Lead = NumW - QW;
    localparam int RW   = DetW + 1;

    logic [RW-1:0]   r_rem [QW+1];
    logic [NumW-1:0] r_num [QW+1];
    logic [DetW-1:0] r_den [QW+1];
    logic [QW-1:0]   r_q   [QW+1];
    logic            r_neg [QW+1];
    logic            r_ovf [QW+1];
    logic signed [OutW-1:0] r_out;

    logic [MagW-1:0] cmag;
    logic [DetW-1:0] dmag;
    logic [NumW-1:0] num0;
    logic [NumW:0]   hi_part;
    logic [QW:0]     qr;

    function automatic logic signed [OutW-1:0] o_next();
        logic up;
        logic [QW:0] m;
        up = ({r_rem[QW], 1'b0} >= {1'b0, RW'(r_den[QW])});
        m  = {1'b0, r_q[QW]} + (QW+1)'(up);
        if (!r_neg[QW]) begin
            if (r_ovf[QW] || m > (QW+1)'(32'h7FFFFFFF)) return {1'b0, {(OutW-1){1'b1}}};
            return OutW'(m);
        end
        if (r_ovf[QW] || m > (QW+1)'(33'h080000000)) return {1'b1, {(OutW-1){1'b0}}};
        return OutW'(-m);
    endfunction

    always_comb begin
        cmag = i_cof[CofW-1] ? MagW'(-i_cof) : MagW'(i_cof);
        dmag = i_det[DetW-1] ? DetW'(-i_det) : DetW'(i_det);
        num0 = {cmag, ShiftW'(0)};
        hi_part = (NumW+1)'(num0 >> QW);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= num0 << Lead;
            r_rem[0] <= RW'(hi_part);
            r_den[0] <= dmag;
            r_q[0]   <= '0;
            r_neg[0] <= i_cof[CofW-1] ^ i_det[DetW-1];
            r_ovf[0] <= ((NumW+1)'(dmag) <= hi_part);
            for (int s = 0; s < QW; s++) begin
                logic [RW-1:0] t;
                t = {r_rem[s][RW-2:0], r_num[s][NumW-1]};
                if (t >= RW'(r_den[s])) begin
                    r_rem[s+1] <= t - RW'(r_den[s]);
                    r_q[s+1]   <= {r_q[s][QW-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= t;
                    r_q[s+1]   <= {r_q[s][QW-2:0], 1'b0};
                end
                r_num[s+1] <= r_num[s] << 1;
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
                r_ovf[s+1] <= r_ovf[s];
            end
            r_out <= o_next();
        end
    end

    assign qr = '0;
    assign o_q = r_out | OutW'(qr);
endmodule
